// File: src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared codes for the placement state stepper: placement states and
// command kinds.
// ----------------------------------------------------------------------------
package pss_pkg;

   typedef logic [2:0] state_type;
   typedef logic [1:0] cmd_type;

   localparam state_type ST_CLOSE = 3'd0;
   localparam state_type ST_OPEN  = 3'd1;
   localparam state_type ST_FETCH = 3'd2;
   localparam state_type ST_UP    = 3'd3;
   localparam state_type ST_DOWN  = 3'd4;
   localparam state_type ST_PUTIN = 3'd5;
   localparam state_type ST_NONE  = 3'd6;

   localparam cmd_type CMD_REQUEST = 2'd0;
   localparam cmd_type CMD_TICK    = 2'd1;
   localparam cmd_type CMD_INIT    = 2'd2;

   localparam logic [2:0] STATUS_LAST = 3'd3;

endpackage

// File: src/placement_state_stepper.sv
// ----------------------------------------------------------------------------
// placement_state_stepper
// Walks the placement state one legal step per tick toward a requested target.
// ----------------------------------------------------------------------------
// Each request word yields exactly one response word. A word goes through an
// input register, one pass of the transition tables, and the response
// register; one word is taken every cycle while the response side keeps up,
// and the input stage keeps accepting while a finished response waits,
// stalling only when both stages hold words. The placement state lives in
// registers updated as each word leaves the input register, so consecutive
// words see each other's effects.
module placement_state_stepper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [2:0] target_state, [5:3] placement_status
   input  logic [1:0] req_tuser,   // [1:0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] event_code, [5:3] settled_state
   output logic       rsp_tuser    // [0] event_valid
);

   logic                in_valid_ff, in_valid_in;
   pss_pkg::cmd_type    in_cmd_ff;
   pss_pkg::state_type  in_tgt_ff;
   logic [2:0]          in_status_ff;

   pss_pkg::state_type  cur_ff, cur_in;
   pss_pkg::state_type  tgt_ff, tgt_in;
   logic                armed_ff, armed_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_event_ff, out_event_in;
   pss_pkg::state_type  out_code_ff, out_code_in;
   pss_pkg::state_type  out_settled_ff, out_settled_in;

   logic                advance;
   logic                direct_ok;
   pss_pkg::state_type  corr;
   logic [2:0]          pos_cur, pos_tgt;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      case (tgt_ff)
         pss_pkg::ST_CLOSE: direct_ok = cur_ff == pss_pkg::ST_OPEN  || cur_ff == pss_pkg::ST_PUTIN;
         pss_pkg::ST_OPEN:  direct_ok = cur_ff == pss_pkg::ST_CLOSE;
         pss_pkg::ST_FETCH: direct_ok = cur_ff == pss_pkg::ST_OPEN  || cur_ff == pss_pkg::ST_PUTIN;
         pss_pkg::ST_UP:    direct_ok = cur_ff == pss_pkg::ST_DOWN  || cur_ff == pss_pkg::ST_FETCH;
         pss_pkg::ST_DOWN:  direct_ok = cur_ff == pss_pkg::ST_UP;
         pss_pkg::ST_PUTIN: direct_ok = cur_ff == pss_pkg::ST_DOWN  || cur_ff == pss_pkg::ST_FETCH;
         default:           direct_ok = 1'b0;
      endcase
   end

   always_comb begin
      corr = pss_pkg::ST_NONE;
      case (tgt_ff)
         pss_pkg::ST_CLOSE: begin
            if (cur_ff == pss_pkg::ST_UP) corr = pss_pkg::ST_DOWN;
            else if (cur_ff == pss_pkg::ST_DOWN || cur_ff == pss_pkg::ST_FETCH)
               corr = pss_pkg::ST_PUTIN;
            else if (cur_ff == pss_pkg::ST_PUTIN) corr = pss_pkg::ST_CLOSE;
         end
         pss_pkg::ST_DOWN, pss_pkg::ST_UP: begin
            if (cur_ff == pss_pkg::ST_PUTIN || cur_ff == pss_pkg::ST_OPEN)
               corr = pss_pkg::ST_FETCH;
            else if (cur_ff == pss_pkg::ST_FETCH) corr = pss_pkg::ST_UP;
            else if (cur_ff == pss_pkg::ST_CLOSE) corr = pss_pkg::ST_OPEN;
         end
         pss_pkg::ST_PUTIN, pss_pkg::ST_OPEN: begin
            if (cur_ff == pss_pkg::ST_UP) corr = pss_pkg::ST_DOWN;
            else if (cur_ff == pss_pkg::ST_DOWN) corr = pss_pkg::ST_PUTIN;
         end
         pss_pkg::ST_FETCH: begin
            if (cur_ff == pss_pkg::ST_UP) corr = pss_pkg::ST_DOWN;
            else if (cur_ff == pss_pkg::ST_DOWN) corr = pss_pkg::ST_PUTIN;
            else if (cur_ff == pss_pkg::ST_CLOSE) corr = pss_pkg::ST_OPEN;
         end
         default: corr = pss_pkg::ST_NONE;
      endcase
   end

   assign pos_cur = (cur_ff <= pss_pkg::ST_PUTIN) ? cur_ff : 3'd0;
   assign pos_tgt = (tgt_ff <= pss_pkg::ST_PUTIN) ? tgt_ff : 3'd0;

   always_comb begin
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      armed_in     = armed_ff;
      out_event_in = 1'b0;
      out_code_in  = 3'd0;
      case (in_cmd_ff)
         pss_pkg::CMD_REQUEST: begin
            if (in_tgt_ff <= pss_pkg::ST_PUTIN) begin
               tgt_in = in_tgt_ff;
               if (cur_ff != in_tgt_ff) armed_in = 1'b1;
            end
         end
         pss_pkg::CMD_INIT: begin
            if (in_status_ff <= pss_pkg::STATUS_LAST) begin
               cur_in = in_status_ff;
               tgt_in = in_status_ff;
            end
         end
         pss_pkg::CMD_TICK: begin
            if (armed_ff) begin
               if (cur_ff == pss_pkg::ST_NONE) begin
                  cur_in = tgt_ff;
                  if (tgt_ff <= pss_pkg::ST_PUTIN) begin
                     out_event_in = 1'b1;
                     out_code_in  = tgt_ff;
                  end
               end else if (cur_ff == tgt_ff) begin
                  armed_in = 1'b0;
               end else if (direct_ok) begin
                  cur_in       = tgt_ff;
                  out_event_in = 1'b1;
                  out_code_in  = tgt_ff;
               end else if (pos_cur < pos_tgt) begin
                  cur_in       = pos_cur + 3'd1;
                  out_event_in = 1'b1;
                  out_code_in  = pos_cur + 3'd1;
               end else begin
                  if (corr != pss_pkg::ST_NONE) begin
                     cur_in       = corr;
                     out_event_in = 1'b1;
                     out_code_in  = corr;
                  end
                  // drop stepping when parked at put in or fetch out toward open
                  if (tgt_ff == pss_pkg::ST_OPEN &&
                      (cur_in == pss_pkg::ST_PUTIN || cur_in == pss_pkg::ST_FETCH))
                     armed_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      out_settled_in = (cur_in == tgt_in) ? cur_in : pss_pkg::ST_NONE;
   end

   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cur_ff       <= pss_pkg::ST_NONE;
         tgt_ff       <= pss_pkg::ST_NONE;
         armed_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cur_ff   <= cur_in;
            tgt_ff   <= tgt_in;
            armed_ff <= armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff    <= req_tuser;
         in_tgt_ff    <= req_tdata[2:0];
         in_status_ff <= req_tdata[5:3];
      end
      if (advance) begin
         out_event_ff   <= out_event_in;
         out_code_ff    <= out_code_in;
         out_settled_ff <= out_settled_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_event_ff;
   assign rsp_tdata  = {2'b00, out_settled_ff, out_code_ff};

endmodule

// File: src/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks on the placement state stepper response stream.
// ----------------------------------------------------------------------------
module pss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_no_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[2:0] == pss_pkg::ST_CLOSE)
      else $error("event code set without event");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:3] <= pss_pkg::ST_NONE && rsp_tdata[2:0] <= pss_pkg::ST_PUTIN
         && rsp_tdata[7:6] == 2'b00)
      else $error("response field out of range");

   a_event_leaves_unsettled_or_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[5:3] != pss_pkg::ST_NONE
         |-> rsp_tdata[5:3] == rsp_tdata[2:0])
      else $error("settled state differs from entered state");

endmodule

bind placement_state_stepper pss_checker u_pss_checker (.*);
